FILE: hdl/scpf_pkg.sv
// ----------------------------------------------------------------------------
// scpf_pkg
// Types and fixed constants shared by the strip charge peak finder modules.
// ----------------------------------------------------------------------------
package scpf_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int CSR_W         = 5;
   localparam int CNT_W         = 6;
   localparam int CHARGE_W      = 18;
   localparam int ACC_W         = 20;
   localparam int STRIP_NUM_W   = 7;
   localparam int STRIP_CNT_W   = 8;
   localparam int RSP_DATA_W    = 32;

   localparam logic [SAMPLE_W-1:0] OVER_LIMIT = 16'd32768;
   localparam logic [CHARGE_W-1:0] CHARGE_MAX = 18'h3FFFF;
   localparam logic [CSR_W-1:0]    CSR_RESET  = 5'd16;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_SETUP,
      ST_SUM,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic setup;
      logic read;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic strip_end;
      logic last_read;
   } status_type;

endpackage

FILE: hdl/strip_charge_peak_finder.sv
// ----------------------------------------------------------------------------
// strip_charge_peak_finder
// Per-strip charge around the peak sample, with the layer's peak strip.
// ----------------------------------------------------------------------------
// Usage: ADC samples enter on the req_ channel, samples_per_strip of them for
// each strip, strips in order within a layer. Samples above 32768 count as
// zero. One item leaves on the rsp_ channel per strip: the window sum around
// the strip's first maximum sample, the one-based strip number, the best strip
// of the layer so far, and tlast on the last strip of the layer.
// Samples within a strip are taken one per cycle. After the last sample the
// block passes a setup state, reads the window samples from the sample RAM
// (at most 2*WINDOW_HALF+1), then passes a drain state and a result state.
// The single read port of the sample RAM sets the window walk.
// The result sits in an output register; the next strip's samples are taken
// while it waits. If the receiver still holds the previous result when a new
// one is ready, the block waits and stops taking samples until it is taken.
// The csr_ port writes samples_per_strip (reset value 16) and is always ready;
// the user must write it only while no strip is in progress (unenforced).
// A synchronous reset clears the counters, the layer peak and the result valid.
// ----------------------------------------------------------------------------
module strip_charge_peak_finder #(
   parameter int MAX_SAMPLES      = 16,
   parameter int STRIPS_PER_LAYER = 80,
   parameter int WINDOW_HALF      = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scpf_pkg::CSR_W-1:0]          csr_data,    // samples_per_strip
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [scpf_pkg::SAMPLE_W-1:0]       req_tdata,   // adc_sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // strip_charge [17:0], strip_number [24:18], lead_strip [31:25]
   output logic [scpf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast    // layer_done
);
   import scpf_pkg::*;

   cmd_type                cmd;
   status_type             status;
   logic [CHARGE_W-1:0]    strip_charge;
   logic [STRIP_NUM_W-1:0] strip_number;
   logic [STRIP_NUM_W-1:0] lead_strip;

   assign csr_ready = 1'b1;

   scpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   scpf_dp #(
      .MAX_SAMPLES      (MAX_SAMPLES),
      .STRIPS_PER_LAYER (STRIPS_PER_LAYER),
      .WINDOW_HALF      (WINDOW_HALF)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .adc_sample   (req_tdata),
      .cmd          (cmd),
      .status       (status),
      .strip_charge (strip_charge),
      .strip_number (strip_number),
      .lead_strip   (lead_strip),
      .layer_done   (rsp_tlast)
   );

   assign rsp_tdata = {lead_strip, strip_number, strip_charge};

endmodule

FILE: hdl/scpf_ram.sv
// ----------------------------------------------------------------------------
// scpf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module scpf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/scpf_ctrl.sv
// ----------------------------------------------------------------------------
// scpf_ctrl
// Sequencer: collects samples, walks the charge window, then hands the
// result to the output register.
// ----------------------------------------------------------------------------
module scpf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  scpf_pkg::status_type status,
   output scpf_pkg::cmd_type   cmd
);
   import scpf_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_COLLECT: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && status.strip_end) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.read = 1'b1;
            if (status.last_read) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: hdl/scpf_dp.sv
// ----------------------------------------------------------------------------
// scpf_dp
// Datapath: sample store, running maximum, window accumulator, layer peak
// tracking and the result register.
// ----------------------------------------------------------------------------
module scpf_dp #(
   parameter int MAX_SAMPLES      = 16,
   parameter int STRIPS_PER_LAYER = 80,
   parameter int WINDOW_HALF      = 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [scpf_pkg::CSR_W-1:0]             csr_data,
   input  logic [scpf_pkg::SAMPLE_W-1:0]          adc_sample,
   input  scpf_pkg::cmd_type                      cmd,
   output scpf_pkg::status_type                   status,
   output logic [scpf_pkg::CHARGE_W-1:0]          strip_charge,
   output logic [scpf_pkg::STRIP_NUM_W-1:0]       strip_number,
   output logic [scpf_pkg::STRIP_NUM_W-1:0]       lead_strip,
   output logic                                   layer_done
);
   import scpf_pkg::*;

   localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int WIN_W = IDX_W + 3;

   logic [CSR_W-1:0]       samples_ff;
   logic [IDX_W-1:0]       index_ff;
   logic [IDX_W-1:0]       end_idx_ff;
   logic [SAMPLE_W-1:0]    max_value_ff;
   logic [IDX_W-1:0]       max_pos_ff;
   logic [WIN_W-1:0]       k_ff;
   logic [WIN_W-1:0]       last_ff;
   logic                   pend_ff;
   logic [ACC_W-1:0]       acc_ff;
   logic [STRIP_CNT_W-1:0] strip_ff;
   logic [CHARGE_W-1:0]    best_charge_ff;
   logic [STRIP_NUM_W-1:0] best_strip_ff;
   logic [CHARGE_W-1:0]    out_charge_ff;
   logic [STRIP_NUM_W-1:0] out_number_ff;
   logic [STRIP_NUM_W-1:0] out_peak_ff;
   logic                   out_done_ff;

   logic [CNT_W-1:0]       count;
   logic [CNT_W-1:0]       received;
   logic [SAMPLE_W-1:0]    sample;
   logic [SAMPLE_W-1:0]    rd_data;
   logic [WIN_W-1:0]       pos_w;
   logic [WIN_W-1:0]       hi_w;
   logic [WIN_W-1:0]       end_w;
   logic [CHARGE_W-1:0]    sat_charge;
   logic [STRIP_CNT_W-1:0] number;
   logic                   better;
   logic                   done;

   // Out-of-range counts are pulled into one to MAX_SAMPLES.
   always_comb begin
      if (samples_ff == '0) begin
         count = CNT_W'(1);
      end else if (CNT_W'(samples_ff) > CNT_W'(MAX_SAMPLES)) begin
         count = CNT_W'(MAX_SAMPLES);
      end else begin
         count = CNT_W'(samples_ff);
      end
   end

   assign sample   = (adc_sample > OVER_LIMIT) ? '0 : adc_sample;
   assign received = CNT_W'(index_ff) + CNT_W'(1);

   assign status.strip_end = (received >= count);
   assign status.last_read = (k_ff == last_ff);

   assign pos_w = WIN_W'(max_pos_ff);
   assign hi_w  = pos_w + WIN_W'(WINDOW_HALF);
   assign end_w = WIN_W'(end_idx_ff);

   assign sat_charge = (acc_ff > ACC_W'(CHARGE_MAX)) ? CHARGE_MAX : acc_ff[CHARGE_W-1:0];
   assign number     = strip_ff + STRIP_CNT_W'(1);
   assign better     = (sat_charge > best_charge_ff);
   assign done       = (number >= STRIP_CNT_W'(STRIPS_PER_LAYER));

   scpf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (index_ff),
      .wr_data (sample),
      .rd_addr (k_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff     <= CSR_RESET;
         index_ff       <= '0;
         max_value_ff   <= '0;
         max_pos_ff     <= '0;
         pend_ff        <= 1'b0;
         strip_ff       <= '0;
         best_charge_ff <= '0;
         best_strip_ff  <= '0;
      end else begin
         if (csr_valid) begin
            samples_ff <= csr_data;
         end
         pend_ff <= cmd.read;
         if (cmd.accept) begin
            // The first sample of a strip always restarts the maximum search.
            if (index_ff == '0 || sample > max_value_ff) begin
               max_value_ff <= sample;
               max_pos_ff   <= index_ff;
            end
            if (status.strip_end) begin
               index_ff <= '0;
            end else begin
               index_ff <= received[IDX_W-1:0];
            end
         end
         if (cmd.finish) begin
            if (done) begin
               strip_ff       <= '0;
               best_charge_ff <= '0;
               best_strip_ff  <= '0;
            end else begin
               strip_ff <= number;
               if (better) begin
                  best_charge_ff <= sat_charge;
                  best_strip_ff  <= number[STRIP_NUM_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         end_idx_ff <= index_ff;
      end
      if (cmd.setup) begin
         k_ff    <= (pos_w >= WIN_W'(WINDOW_HALF)) ? pos_w - WIN_W'(WINDOW_HALF) : '0;
         last_ff <= (hi_w > end_w) ? end_w : hi_w;
         acc_ff  <= '0;
      end else begin
         if (cmd.read) begin
            k_ff <= k_ff + WIN_W'(1);
         end
         if (pend_ff) begin
            acc_ff <= acc_ff + ACC_W'(rd_data);
         end
      end
      if (cmd.finish) begin
         out_charge_ff <= sat_charge;
         out_number_ff <= number[STRIP_NUM_W-1:0];
         out_peak_ff   <= better ? number[STRIP_NUM_W-1:0] : best_strip_ff;
         out_done_ff   <= done;
      end
   end

   assign strip_charge = out_charge_ff;
   assign strip_number = out_number_ff;
   assign lead_strip   = out_peak_ff;
   assign layer_done   = out_done_ff;

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strip charge peak finder.
// ----------------------------------------------------------------------------
// ADC samples are sent as whole strips on the req_ channel. A scoreboard
// predicts each strip result from the samples it sees accepted, and compares
// every result taken from the rsp_ channel field by field. The sample count
// register is rewritten between phases, including the out-of-range values 0
// and 31. Both the sender and the receiver idle in short random bursts in
// phases with idling on (some pick it at random); the last runs at full rate.
// ----------------------------------------------------------------------------
module tb_top;
   import scpf_pkg::*;

   localparam int MAX_SAMPLES      = 16;
   localparam int STRIPS_PER_LAYER = 80;
   localparam int WINDOW_HALF      = 2;
   localparam int DRAIN_CYCLES     = 40;
   localparam int WATCHDOG_LIMIT   = 2000;

   typedef struct {
      logic [CHARGE_W-1:0]    charge;
      logic [STRIP_NUM_W-1:0] number;
      logic [STRIP_NUM_W-1:0] peak;
      logic                   done;
   } strip_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_W-1:0]      csr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   bit                    idle_enable = 1'b0;
   int unsigned           hold_count = 0;
   int unsigned           quiet_cycles = 0;

   function automatic int unsigned strip_length(input logic [CSR_W-1:0] setting);
      if (setting == 0)
         return 1;
      if (setting > MAX_SAMPLES)
         return MAX_SAMPLES;
      return 32'(setting);
   endfunction

   class strip_scoreboard;
      logic [SAMPLE_W-1:0]    samples [MAX_SAMPLES];
      logic [CSR_W-1:0]       sample_count;
      logic [CSR_W-1:0]       fill;
      logic [SAMPLE_W-1:0]    peak_value;
      logic [CSR_W-1:0]       peak_index;
      logic [STRIP_NUM_W-1:0] strips_done;
      logic [CHARGE_W-1:0]    best_charge;
      logic [STRIP_NUM_W-1:0] best_strip;
      strip_result_type       expected [$];
      int unsigned            errors;

      function new();
         sample_count = CSR_RESET;
         fill         = '0;
         peak_value   = '0;
         peak_index   = '0;
         strips_done  = '0;
         best_charge  = '0;
         best_strip   = '0;
         errors       = 0;
      endfunction

      function void set_count(input logic [CSR_W-1:0] value);
         sample_count = value;
      endfunction

      function int unsigned pending();
         return expected.size();
      endfunction

      // Runs the strip logic for one accepted sample; a result is queued at
      // the end of each strip.
      function void note_sample(input logic [SAMPLE_W-1:0] raw);
         logic [SAMPLE_W-1:0]    adc;
         logic [CSR_W-1:0]       slot;
         int unsigned            lo;
         int unsigned            hi;
         logic [ACC_W-1:0]       sum;
         strip_result_type       res;

         adc = (raw > OVER_LIMIT) ? '0 : raw;
         slot = (fill >= MAX_SAMPLES) ? CSR_W'(MAX_SAMPLES - 1) : fill;
         samples[slot] = adc;
         if (slot == 0 || adc > peak_value) begin
            peak_value = adc;
            peak_index = slot;
         end
         if (slot + 1 < strip_length(sample_count)) begin
            fill = slot + CSR_W'(1);
            return;
         end

         // The window around the first maximum is clipped to the strip.
         lo = (peak_index >= WINDOW_HALF) ? peak_index - WINDOW_HALF : 0;
         hi = peak_index + WINDOW_HALF;
         if (hi > slot)
            hi = slot;
         sum = '0;
         for (int unsigned k = lo; k <= hi; k++)
            sum += ACC_W'(samples[k]);
         if (sum > ACC_W'(CHARGE_MAX))
            sum = ACC_W'(CHARGE_MAX);

         res.charge = sum[CHARGE_W-1:0];
         res.number = strips_done + STRIP_NUM_W'(1);
         if (res.charge > best_charge) begin
            best_charge = res.charge;
            best_strip  = res.number;
         end
         res.peak = best_strip;
         res.done = (res.number >= STRIPS_PER_LAYER);
         expected.insert(expected.size(), res);

         fill       = '0;
         peak_value = '0;
         peak_index = '0;
         if (res.done) begin
            strips_done = '0;
            best_charge = '0;
            best_strip  = '0;
         end else begin
            strips_done = res.number;
         end
      endfunction

      function void compare_field(input string name, input int unsigned want,
                                  input int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(input logic [RSP_DATA_W-1:0] data, input logic last);
         strip_result_type res;

         if (expected.size() == 0) begin
            $error("strip result with none expected: tdata %h, tlast %b", data, last);
            errors++;
            return;
         end
         res = expected.pop_front();
         compare_field("strip_charge", res.charge, data[17:0]);
         compare_field("strip_number", res.number, data[24:18]);
         compare_field("lead_strip", res.peak, data[31:25]);
         compare_field("layer_done", res.done, last);
      endfunction
   endclass

   strip_scoreboard tracker = new();

   strip_charge_peak_finder #(
      .MAX_SAMPLES      (MAX_SAMPLES),
      .STRIPS_PER_LAYER (STRIPS_PER_LAYER),
      .WINDOW_HALF      (WINDOW_HALF)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Receiver: while idling is on, rsp_tready drops at random in bursts.
   always @(posedge clock) begin
      if (reset || !idle_enable) begin
         hold_count <= 0;
         rsp_tready <= 1'b1;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         hold_count <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Observes every handshake, feeds the scoreboard and guards against a hang.
   always @(posedge clock) begin
      if (csr_valid && csr_ready)
         tracker.set_count(csr_data);
      if (req_tvalid && req_tready)
         tracker.note_sample(req_tdata);
      if (rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata, rsp_tlast);
      if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
          (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [SAMPLE_W-1:0] random_adc();
      int unsigned pick;

      pick = $urandom_range(0, 9);
      if (pick < 2)
         return SAMPLE_W'($urandom_range(32'd32769, 32'd65535));
      if (pick == 2)
         return OVER_LIMIT;
      if (pick == 3)
         return '0;
      return SAMPLE_W'($urandom_range(0, 32767));
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Lets every expected strip result arrive, then waits out the pipeline.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // One strip whose shape varies: empty, flat (all ties), a
   // full-scale sample at a random spot, or random samples.
   task automatic send_strip(input int unsigned count);
      int unsigned         shape;
      int unsigned         spot;
      logic [SAMPLE_W-1:0] level;

      shape = $urandom_range(0, 5);
      spot  = $urandom_range(0, count - 1);
      level = random_adc();
      for (int unsigned k = 0; k < count; k++) begin
         case (shape)
            0: begin
               send_sample($urandom_range(0, 1) ? SAMPLE_W'(0) :
                           SAMPLE_W'($urandom_range(32'd32769, 32'd65535)));
            end
            1: begin
               send_sample(level);
            end
            2: begin
               send_sample((k == spot) ? OVER_LIMIT : random_adc());
            end
            default: begin
               send_sample(random_adc());
            end
         endcase
      end
   endtask

   task automatic run_phase(input logic [CSR_W-1:0] setting, input int unsigned strips,
                            input bit idling);
      settle();
      write_count(setting);
      idle_enable = idling;
      repeat (strips) send_strip(strip_length(setting));
   endtask

   initial begin
      logic [SAMPLE_W-1:0] full_strip [16] = '{
         16'd65535, 16'd32769, 16'd0, 16'd1, 16'd2, 16'd40000, 16'd32767, 16'd10,
         16'd20, 16'd30, 16'd40, 16'd50, 16'd60, 16'd100, 16'd32768, 16'd32768
      };
      logic [SAMPLE_W-1:0] single_strips [6] = '{
         16'd0, 16'd32768, 16'd32769, 16'd32768, 16'd65535, 16'd1
      };
      int unsigned         span;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset count of 16: over-limit samples, and a tied maximum near the
      // end so the window is clipped on the right.
      foreach (full_strip[k])
         send_sample(full_strip[k]);

      // One sample per strip: zero charge, full scale, and a tie that must
      // leave the earlier strip as the peak.
      settle();
      write_count(CSR_W'(1));
      foreach (single_strips[k])
         send_sample(single_strips[k]);

      run_phase(CSR_W'(1), 90, $urandom_range(0, 3) != 0);
      run_phase(CSR_W'(2), 20, $urandom_range(0, 3) != 0);
      run_phase(CSR_W'(16), 3, 1'b1);
      run_phase(CSR_W'(0), 30, $urandom_range(0, 3) != 0);
      run_phase(CSR_W'(31), 2, $urandom_range(0, 3) != 0);
      run_phase(CSR_W'(5), 10, 1'b1);
      run_phase(CSR_W'(3), 20, $urandom_range(0, 3) != 0);
      span = $urandom_range(1, 16);
      run_phase(CSR_W'(span), 48 / span + 1, 1'b0);

      settle();
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("All tests passed");
      end else begin
         if (tracker.pending() != 0)
            $error("%0d strip results never arrived", tracker.pending());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
